// ----- design/i2rs_pkg.sv -----
package i2rs_pkg;

    // Digit store
    localparam int DIGIT_SLOTS = 64;
    localparam int SLOT_W      = $clog2(DIGIT_SLOTS);

    // Field widths
    localparam int VALUE_W     = 64;
    localparam int RADIX_W     = 6;
    localparam int DIGIT_W     = 6;
    localparam int CHAR_W      = 7;
    localparam int IN_DATA_W   = 72;
    localparam int OUT_DATA_W  = 8;

    // Divider: quotient bits resolved per cycle
    localparam int CHUNK_W     = 8;
    localparam int STEPS       = VALUE_W / CHUNK_W;
    localparam int STEP_W      = $clog2(STEPS);

    localparam logic [RADIX_W-1:0] MIN_BASE   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_HIGH = RADIX_W'(36);
    localparam logic [DIGIT_W-1:0] DEC_DIGITS = DIGIT_W'(10);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

    typedef struct packed {
        logic [DIGIT_W-1:0] rem;
        logic [CHUNK_W-1:0] chunk;
        logic [RADIX_W-1:0] radix;
    } div_req_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] rem;
        logic [CHUNK_W-1:0] quo;
    } div_rsp_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        if (d < DEC_DIGITS)
        begin
            return CHAR_ZERO + CHAR_W'(d);
        end
        return CHAR_A + CHAR_W'(d - DEC_DIGITS);
    endfunction

endpackage

// ----- design/i2rs_ram.sv -----
module i2rs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/i2rs_div_unit.sv -----
module i2rs_div_unit
    import i2rs_pkg::*;
(
    input  div_req_t req,
    output div_rsp_t rsp
);

    // Restoring long division over one chunk of dividend bits, MSB first.
    // The running remainder stays below the radix, so it fits DIGIT_W bits.
    always_comb
    begin
        logic [DIGIT_W:0]   part;
        logic [DIGIT_W-1:0] rem;
        logic [CHUNK_W-1:0] quo;
        rem  = req.rem;
        quo  = '0;
        part = '0;
        for (int i = CHUNK_W - 1; i >= 0; i--)
        begin
            part = {rem, req.chunk[i]};
            if (part >= {1'b0, req.radix})
            begin
                part   = part - {1'b0, req.radix};
                quo[i] = 1'b1;
            end
            rem = part[DIGIT_W-1:0];
        end
        rsp.rem = rem;
        rsp.quo = quo;
    end

endmodule

// ----- design/integer_to_radix_string_core.sv -----
// Channel   Dir  Signals                     Contents (lowest bit up)
// s_*       in   s_tvalid s_tready s_tdata   value[63:0], radix[69:64], zero pad to 72
// m_*       out  m_tvalid m_tready m_tdata   char_code[6:0], zero pad to 8
//                m_tlast m_tuser             last; error
//
// Sequence: the accept, then each digit in the shared divider (8 quotient
// bits a cycle over a 64-bit dividend), then the sign state that primes the
// digit store read and sends a leading minus sign, then one character per cycle
// while m_tready is high. A refused item gives a single error beat.
// Reset clears the sequencer and the output valid flag; the digit store needs none.
// s_tready is high only in the idle state; a stalled m_tready holds the sequencer.
module integer_to_radix_string_core
    import i2rs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // value[63:0], radix[69:64]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // char_code[6:0]
    output logic                  m_tlast,
    output logic                  m_tuser    // error
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ERR   = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_SIGN  = 3'd3;
    localparam logic [2:0] S_DIGIT = 3'd4;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS - 1);

    logic [2:0]          state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [SLOT_W-1:0]   idx_reg, idx_next;
    logic [VALUE_W-1:0]  work_reg, work_next;
    logic [DIGIT_W-1:0]  rem_reg, rem_next;
    logic [RADIX_W-1:0]  radix_reg, radix_next;
    logic                neg_reg, neg_next;

    logic                out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]   out_char_reg, out_char_next;
    logic                out_last_reg, out_last_next;
    logic                out_err_reg, out_err_next;
    logic                out_load;
    logic                out_free;

    logic [VALUE_W-1:0]  value_in;
    logic [RADIX_W-1:0]  radix_in;
    logic [VALUE_W-1:0]  neg_value;
    logic [VALUE_W-1:0]  mag_in;
    logic                bad_in;
    logic                accept;

    div_req_t            div_req;
    div_rsp_t            div_rsp;
    logic [VALUE_W-1:0]  quo_shift;

    logic                ram_we;
    logic [DIGIT_W-1:0]  ram_rdata;

    // Input decode
    assign value_in  = s_tdata[VALUE_W-1:0];
    assign radix_in  = s_tdata[VALUE_W+RADIX_W-1:VALUE_W];
    assign neg_value = ~value_in + VALUE_W'(1);
    // Drop the sign bit: the most negative value is refused, so it is never needed.
    assign mag_in    = value_in[VALUE_W-1] ? {1'b0, neg_value[VALUE_W-2:0]}
                                           : {1'b0, value_in[VALUE_W-2:0]};
    assign bad_in    = (radix_in < MIN_BASE) || (radix_in > RADIX_HIGH)
                    || (value_in == {1'b1, {(VALUE_W-1){1'b0}}});

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || m_tready;

    // Shared divider: the work register is dividend and quotient at once,
    // shifted up by one chunk per cycle with fresh quotient bits at the bottom.
    assign div_req.rem   = rem_reg;
    assign div_req.chunk = work_reg[VALUE_W-1:VALUE_W-CHUNK_W];
    assign div_req.radix = radix_reg;
    assign quo_shift     = {work_reg[VALUE_W-CHUNK_W-1:0], div_rsp.quo};

    i2rs_div_unit u_div (
        .req (div_req),
        .rsp (div_rsp)
    );

    // Digit store: written least significant digit first, read back downwards.
    // The read address runs on the next index so the registered data matches the index.
    assign ram_we = (state_reg == S_DIV) && (step_reg == STEP_LAST);

    i2rs_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (DIGIT_SLOTS)
    ) u_digits (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (div_rsp.rem),
        .raddr (idx_next),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        idx_next      = idx_reg;
        work_next     = work_reg;
        rem_next      = rem_reg;
        radix_next    = radix_reg;
        neg_next      = neg_reg;
        out_load      = 1'b0;
        out_char_next = out_char_reg;
        out_last_next = out_last_reg;
        out_err_next  = out_err_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (bad_in)
                    begin
                        state_next = S_ERR;
                    end
                    else
                    begin
                        work_next  = mag_in;
                        rem_next   = '0;
                        step_next  = '0;
                        idx_next   = '0;
                        radix_next = radix_in;
                        neg_next   = value_in[VALUE_W-1];
                        state_next = S_DIV;
                    end
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_char_next = '0;
                    out_last_next = 1'b1;
                    out_err_next  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_DIV:
            begin
                work_next = quo_shift;
                rem_next  = div_rsp.rem;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST)
                begin
                    // Digit complete: restart the remainder for the next one.
                    rem_next  = '0;
                    step_next = '0;
                    if (quo_shift == '0)
                    begin
                        state_next = S_SIGN;
                    end
                    else
                    begin
                        idx_next = idx_reg + SLOT_W'(1);
                    end
                end
            end
            S_SIGN:
            begin
                if (!neg_reg)
                begin
                    state_next = S_DIGIT;
                end
                else if (out_free)
                begin
                    out_load      = 1'b1;
                    out_char_next = CHAR_MINUS;
                    out_last_next = 1'b0;
                    out_err_next  = 1'b0;
                    state_next    = S_DIGIT;
                end
            end
            S_DIGIT:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_char_next = digit_char(ram_rdata);
                    out_last_next = (idx_reg == '0);
                    out_err_next  = 1'b0;
                    if (idx_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - SLOT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg     <= step_next;
        idx_reg      <= idx_next;
        work_reg     <= work_next;
        rem_reg      <= rem_next;
        radix_reg    <= radix_next;
        neg_reg      <= neg_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-CHAR_W){1'b0}}, out_char_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_err_reg;

    a_err_beat_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == '0)))
        else $error("error beat without last or with a character");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a conversion starts");

    a_div_ends_on_chunk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && state_next == S_SIGN) |-> (step_reg == STEP_LAST))
        else $error("division left before the last chunk");

    a_digit_follows_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SIGN && state_next == S_DIGIT && neg_reg) |=>
            (m_tvalid && !m_tlast))
        else $error("minus sign not presented before digits");

endmodule

// ----- dv/integer_to_radix_string_checker.sv -----
module integer_to_radix_string_checker
    import i2rs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // value[63:0], radix[69:64]
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,   // char_code[6:0]
    input  logic                  m_tlast,
    input  logic                  m_tuser,   // error
    output int                    mismatch_count,
    output int                    pending_count,
    output int                    items_seen,
    output int                    chars_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
        logic              error;
    } radix_char_t;

    localparam logic [VALUE_W-1:0] MOST_NEGATIVE = {1'b1, {(VALUE_W-1){1'b0}}};

    radix_char_t        expected_chars[$];
    logic [DIGIT_W-1:0] digit_store [DIGIT_SLOTS];
    logic [62:0]        held_magnitude;
    logic [6:0]         held_digit_count;
    logic               held_negative;

    function automatic radix_char_t char_beat(input logic [CHAR_W-1:0] code,
                                              input logic last, input logic error);
        radix_char_t c;
        c.char_code = code;
        c.last      = last;
        c.error     = error;
        return c;
    endfunction

    // Work out every character of one conversion and queue it
    task automatic predict_conversion(input logic [VALUE_W-1:0] value,
                                      input logic [RADIX_W-1:0] radix);
        logic [62:0]       remaining;
        logic [62:0]       divisor;
        logic [CHAR_W-1:0] code;
        int                count;
        count   = 0;
        divisor = 63'(radix);
        if (radix < MIN_BASE || radix > RADIX_HIGH || value == MOST_NEGATIVE)
        begin
            // refused: one error beat, state untouched
            expected_chars.push_back(char_beat('0, 1'b1, 1'b1));
            return;
        end
        held_negative  = value[VALUE_W-1];
        remaining      = held_negative ? 63'(-value) : value[62:0];
        held_magnitude = remaining;
        if (remaining == '0)
        begin
            digit_store[0] = '0;
            count          = 1;
        end
        else
        begin
            while (remaining != '0 && count < DIGIT_SLOTS)
            begin
                digit_store[count] = DIGIT_W'(remaining % divisor);
                remaining          = remaining / divisor;
                count++;
            end
        end
        held_digit_count = 7'(count);
        if (held_negative)
        begin
            expected_chars.push_back(char_beat(CHAR_MINUS, 1'b0, 1'b0));
        end
        for (int k = count - 1; k >= 0; k--)
        begin
            code = CHAR_W'(digit_store[k]);
            if (digit_store[k] >= DEC_DIGITS)
            begin
                code = CHAR_A + code - CHAR_W'(DEC_DIGITS);
            end
            else
            begin
                code = CHAR_ZERO + code;
            end
            expected_chars.push_back(char_beat(code, k == 0, 1'b0));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        radix_char_t oldest;
        int          faults;
        faults = 0;
        if (!rst_n)
        begin
            expected_chars.delete();
            held_magnitude   = '0;
            held_digit_count = '0;
            held_negative    = 1'b0;
            mismatch_count  <= 0;
            pending_count   <= 0;
            items_seen      <= 0;
            chars_seen      <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_conversion(s_tdata[VALUE_W-1:0], s_tdata[VALUE_W +: RADIX_W]);
                items_seen <= items_seen + 1;
            end
            if (m_tvalid && m_tready)
            begin
                chars_seen <= chars_seen + 1;
                if (expected_chars.size() == 0)
                begin
                    $error("unexpected beat: char_code %0h last %0b error %0b",
                           m_tdata[CHAR_W-1:0], m_tlast, m_tuser);
                    faults++;
                end
                else
                begin
                    oldest = expected_chars.pop_front();
                    if (m_tdata[CHAR_W-1:0] !== oldest.char_code)
                    begin
                        $error("char_code mismatch: expected %0h, actual %0h",
                               oldest.char_code, m_tdata[CHAR_W-1:0]);
                        faults++;
                    end
                    if (m_tlast !== oldest.last)
                    begin
                        $error("last mismatch: expected %0b, actual %0b", oldest.last, m_tlast);
                        faults++;
                    end
                    if (m_tuser !== oldest.error)
                    begin
                        $error("error mismatch: expected %0b, actual %0b", oldest.error, m_tuser);
                        faults++;
                    end
                end
            end
            mismatch_count <= mismatch_count + faults;
            pending_count  <= expected_chars.size();
        end
    end

endmodule

// ----- dv/integer_to_radix_string_core_tb.sv -----
module integer_to_radix_string_core_tb
    import i2rs_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Receiver hold-off used to fill the block and stall its input
    localparam int LONG_HOLD    = 3000;
    // Drain time past the slowest conversion before the verdict
    localparam int DRAIN_CYCLES = 600;

    localparam logic [VALUE_W-1:0] MOST_NEGATIVE = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic [VALUE_W-1:0] MOST_POSITIVE = ~MOST_NEGATIVE;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;   // value[63:0], radix[69:64]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // char_code[6:0]
    logic                  m_tlast;
    logic                  m_tuser;         // error

    int mismatch_count;
    int pending_count;
    int items_seen;
    int chars_seen;

    // Receiver control, set by the stimulus process
    bit rx_gaps_on    = 1'b1;
    bit long_hold_req = 1'b0;
    int rx_hold_left  = 0;

    integer_to_radix_string_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    integer_to_radix_string_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .items_seen     (items_seen),
        .chars_seen     (chars_seen)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Mostly no gap or a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 80);
    endfunction

    // Spread magnitudes over all widths so short and long digit strings both appear
    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        v = {$urandom(), $urandom()};
        if ($urandom_range(0, 3) != 0)
        begin
            v = v >> $urandom_range(1, 63);
        end
        if ($urandom_range(0, 1) == 1)
        begin
            v = -v;
        end
        return v;
    endfunction

    // Present one beat, hold it until taken, then idle for a while if asked
    task automatic offer(input logic [VALUE_W-1:0] value, input logic [RADIX_W-1:0] radix,
                         input bit with_gaps);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, radix, value};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        gap = with_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Mostly well-formed conversions; some refused bases, the most negative value and zero
    task automatic offer_random(input bit with_gaps);
        int                 r;
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
        r     = $urandom_range(0, 99);
        value = random_value();
        radix = RADIX_W'($urandom_range(MIN_BASE, RADIX_HIGH));
        if (r < 6)
        begin
            radix = ($urandom_range(0, 1) == 1) ? RADIX_W'($urandom_range(0, 1))
                                                : RADIX_W'($urandom_range(RADIX_HIGH + 1, 63));
        end
        else if (r < 9)
        begin
            value = MOST_NEGATIVE;
            radix = RADIX_W'($urandom_range(0, 63));
        end
        else if (r < 14)
        begin
            value = '0;
        end
        offer(value, radix, with_gaps);
    endtask

    // Receiver: random stalls, stretches of none, and one long hold on request
    initial
    begin : receiver
        int gap;
        forever
        begin
            @(posedge clk);
            if (rx_hold_left > 0)
            begin
                m_tready <= 1'b0;
                rx_hold_left--;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                rx_hold_left  = LONG_HOLD - 1;
                m_tready     <= 1'b0;
            end
            else if (!rx_gaps_on)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                gap = pick_gap();
                if (gap > 0)
                begin
                    m_tready    <= 1'b0;
                    rx_hold_left = gap - 1;
                end
                else
                begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    initial
    begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero, extremes, refused items and the digit boundaries
        offer('0, 6'd10, 1'b1);
        offer('0, MIN_BASE, 1'b1);
        offer(64'd1, MIN_BASE, 1'b1);
        offer(-64'sd1, MIN_BASE, 1'b1);
        offer(MOST_POSITIVE, MIN_BASE, 1'b1);
        offer(MOST_POSITIVE, RADIX_HIGH, 1'b1);
        offer(MOST_POSITIVE, 6'd10, 1'b1);
        offer(MOST_NEGATIVE + 64'd1, MIN_BASE, 1'b1);   // sign plus 63 digits
        offer(MOST_NEGATIVE + 64'd1, RADIX_HIGH, 1'b1);
        offer(MOST_NEGATIVE, 6'd10, 1'b1);
        offer(MOST_NEGATIVE, MIN_BASE, 1'b1);
        offer(MOST_NEGATIVE, 6'd0, 1'b1);
        offer(64'd12345, 6'd0, 1'b1);
        offer(64'd12345, 6'd1, 1'b1);
        offer(64'd12345, RADIX_HIGH + 6'd1, 1'b1);
        offer(64'd12345, 6'd63, 1'b1);
        offer('0, 6'd0, 1'b1);
        offer(64'd35, RADIX_HIGH, 1'b1);
        offer(-64'sd35, RADIX_HIGH, 1'b1);
        offer(64'd36, RADIX_HIGH, 1'b1);
        offer(64'd9, 6'd10, 1'b1);
        offer(64'd10, 6'd16, 1'b1);
        offer(64'h0123_4567_89AB_CDEF, 6'd16, 1'b1);
        offer(-64'sd255, 6'd16, 1'b1);
        offer(64'd100, 6'd3, 1'b1);

        // Random with idling on both sides
        repeat (150) offer_random(1'b1);

        // Random with no idling at all
        rx_gaps_on = 1'b0;
        repeat (80) offer_random(1'b0);

        // Back-pressure: hold the receiver off and keep offering beats back to back
        rx_gaps_on    = 1'b1;
        long_hold_req = 1'b1;
        repeat (15) offer_random(1'b0);

        // Random with idling again
        repeat (90) offer_random(1'b1);

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d items into %0d characters: zero, extremes, refused bases,",
                 items_seen, chars_seen);
        $display("the most negative value, random bases, random stalls and one long hold.");
        if (mismatch_count == 0 && pending_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Generous ceiling, well past the slowest correct run
    initial
    begin : watchdog
        #100_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
